// File: hdl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared widths, register indexes and reset values of the block resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lir_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int RATE_W    = 19;
	localparam int DIV_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 19;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IN_RATE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_BYTES    = 3'd4;

	localparam logic [1:0]        RST_SAMPLE_FORMAT = 2'd0;
	localparam logic              RST_STEREO        = 1'b1;
	localparam logic [RATE_W-1:0] RST_IN_RATE       = 19'd44100;
	localparam logic [RATE_W-1:0] RST_OUT_RATE      = 19'd22050;
	localparam logic              RST_SWAP_BYTES    = 1'b0;

endpackage

`default_nettype wire

// File: hdl/lir_if.sv
// ----------------------------------------------------------------------------
// lir_if
// Valid/ready channels for frames, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lir_in_if import lir_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_left;
	logic [SAMPLE_W-1:0] sample_right;
	logic                block_end;
	modport source (output valid, sample_left, sample_right, block_end, input ready);
	modport sink (input valid, sample_left, sample_right, block_end, output ready);
endinterface

interface lir_out_if import lir_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] out_left;
	logic [SAMPLE_W-1:0] out_right;
	logic                out_last;
	logic                count_clipped;
	modport source (output valid, out_left, out_right, out_last, count_clipped, input ready);
	modport sink (input valid, out_left, out_right, out_last, count_clipped, output ready);
endinterface

interface lir_cfg_if import lir_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/lir_ram.sv
// ----------------------------------------------------------------------------
// lir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/lir_div.sv
// ----------------------------------------------------------------------------
// lir_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_div import lir_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] num,
	input  wire logic [DIV_W-1:0] den,
	output      logic             done,
	output      logic [DIV_W-1:0] quot
);

	localparam int SW = $clog2(DIV_W);

	logic          busy_q;
	logic [SW-1:0] step_q;
	logic [DIV_W:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W:0] rem_sh;
	logic [DIV_W:0] rem_sub;
	logic           fits;

	always_comb begin
		rem_sh  = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		fits    = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub : rem_sh;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign quot = quo_q;

endmodule

`default_nettype wire

// File: hdl/lir_lane.sv
// ----------------------------------------------------------------------------
// lir_lane
// One channel: format to offset binary, linear interpolation, format back.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_lane import lir_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic [1:0]           fmt,
	input  wire logic                 swap,
	input  wire logic [SAMPLE_W-1:0]  raw_a,
	input  wire logic [SAMPLE_W-1:0]  raw_b,
	input  wire logic [FRAC_BITS-1:0] frac,
	output      logic [SAMPLE_W-1:0]  raw_y
);

	localparam int PW = SAMPLE_W + FRAC_BITS + 1;

	logic                 wide;
	logic                 sgn;
	logic [SAMPLE_W-1:0]  ba;
	logic [SAMPLE_W-1:0]  bb;
	logic [FRAC_BITS:0]   wa;
	logic [PW-1:0]        sum;
	logic [SAMPLE_W-1:0]  y;
	logic [SAMPLE_W-1:0]  yf;

	function automatic logic [SAMPLE_W-1:0] bias(input logic [SAMPLE_W-1:0] raw,
		input logic w, input logic s, input logic sw);
		logic [SAMPLE_W-1:0] v;
		begin
			if (w) begin
				v = sw ? {raw[7:0], raw[15:8]} : raw;
				v = v ^ {s, 15'd0};
			end else begin
				v = {8'd0, raw[7:0] ^ {s, 7'd0}};
			end
			return v;
		end
	endfunction

	always_comb begin
		wide = ~fmt[1];
		sgn  = ~fmt[0];
		ba   = bias(raw_a, wide, sgn, swap);
		bb   = bias(raw_b, wide, sgn, swap);
		wa   = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
		sum  = PW'(ba) * PW'(wa) + PW'(bb) * PW'(frac);
		y    = sum[FRAC_BITS +: SAMPLE_W];
		if (wide) begin
			yf = y ^ {sgn, 15'd0};
			yf = swap ? {yf[7:0], yf[15:8]} : yf;
		end else begin
			yf = {8'd0, y[7:0] ^ {sgn, 7'd0}};
		end
		raw_y = yf;
	end

endmodule

`default_nettype wire

// File: hdl/linear_interp_block_resampler_top.sv
// ----------------------------------------------------------------------------
// linear_interp_block_resampler_top
// Block linear-interpolation resampler: loads frames, divides, then emits.
// ----------------------------------------------------------------------------
//  port     dir   contents
//  frames   sink  sample_left, sample_right, block_end
//  results  src   out_left, out_right, out_last, count_clipped
//  cfg      sink  index, data (always ready)
//
//  frames load one per cycle into two mirrored frame RAMs
//  after block_end: a multiply state, then two divisions (frame count, then phase step)
//  then per output frame a read state for the registered RAM read and an interpolate state
//  frames are taken only in the load state, so none during the math or emission; results stall the emitter
//  reset clears control and loads register reset values; RAMs are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_block_resampler_top import lir_pkg::*; #(
	parameter int BLOCK_FRAMES = 64,
	parameter int FRAC_BITS    = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	lir_in_if.sink   frames,
	lir_out_if.source results,
	lir_cfg_if.sink  cfg
);

	localparam int AW = $clog2(BLOCK_FRAMES);
	localparam int CW = AW + 1;
	localparam int NW = DIV_W - FRAC_BITS;

	typedef enum logic [2:0] {
		S_LOAD, S_MUL, S_CNT_GO, S_CNT, S_STEP_GO, S_STEP, S_RD, S_LERP
	} state_t;

	state_t state_q;

	logic [1:0]        fmt_q;
	logic              stereo_q;
	logic [RATE_W-1:0] in_rate_q;
	logic [RATE_W-1:0] out_rate_q;
	logic              swap_q;

	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    n_in_q;
	logic [DIV_W-1:0] prod_q;
	logic [DIV_W-1:0] count_q;
	logic [DIV_W-1:0] delta_q;
	logic [DIV_W-1:0] phase_q;
	logic [CW-1:0]    emit_cnt_q;
	logic [CW-1:0]    emit_idx_q;
	logic             clipped_q;

	logic                ov_q;
	logic [SAMPLE_W-1:0] ol_q;
	logic [SAMPLE_W-1:0] or_q;
	logic                olast_q;
	logic                oclip_q;

	logic             in_acc;
	logic             store_full;
	logic             we;
	logic [2*SAMPLE_W-1:0] wdata;
	logic [CW-1:0]    n_in_next;
	logic             div_start;
	logic [DIV_W-1:0] div_num;
	logic [DIV_W-1:0] div_den;
	logic             div_done;
	logic [DIV_W-1:0] div_quot;
	logic [NW:0]      n_ext;
	logic [NW:0]      n2_ext;
	logic [NW:0]      last_ext;
	logic [AW-1:0]    raddr_a;
	logic [AW-1:0]    raddr_b;
	logic [2*SAMPLE_W-1:0] rd_a;
	logic [2*SAMPLE_W-1:0] rd_b;
	logic [SAMPLE_W-1:0] lane_l;
	logic [SAMPLE_W-1:0] lane_r;
	logic             slot_free;
	logic             clip_now;

	assign frames.ready = (state_q == S_LOAD);
	assign cfg.ready    = 1'b1;
	assign in_acc       = frames.valid && frames.ready;
	assign store_full   = fill_q >= CW'(BLOCK_FRAMES);
	assign we           = in_acc && !store_full;
	assign wdata        = {stereo_q ? frames.sample_right : {SAMPLE_W{1'b0}}, frames.sample_left};
	assign n_in_next    = store_full ? fill_q : fill_q + 1'b1;

	assign div_start = (state_q == S_CNT_GO) || (state_q == S_STEP_GO);
	assign div_num   = (state_q == S_CNT_GO) ? prod_q : (DIV_W'(n_in_q) << FRAC_BITS);
	assign div_den   = (state_q == S_CNT_GO) ? DIV_W'(in_rate_q) : count_q;
	assign clip_now  = div_quot > DIV_W'(BLOCK_FRAMES);

	always_comb begin
		n_ext    = {1'b0, phase_q[DIV_W-1:FRAC_BITS]};
		n2_ext   = n_ext + 1'b1;
		last_ext = (NW+1)'(n_in_q - 1'b1);
		raddr_a  = AW'((n_ext > last_ext) ? last_ext : n_ext);
		raddr_b  = AW'((n2_ext > last_ext) ? last_ext : n2_ext);
	end

	assign slot_free = !ov_q || results.ready;

	lir_ram #(.WIDTH(2*SAMPLE_W), .DEPTH(BLOCK_FRAMES)) u_ram_a (
		.clk(clk), .we(we), .waddr(AW'(fill_q)), .wdata(wdata),
		.raddr(raddr_a), .rdata(rd_a)
	);

	lir_ram #(.WIDTH(2*SAMPLE_W), .DEPTH(BLOCK_FRAMES)) u_ram_b (
		.clk(clk), .we(we), .waddr(AW'(fill_q)), .wdata(wdata),
		.raddr(raddr_b), .rdata(rd_b)
	);

	lir_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_quot)
	);

	lir_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_l (
		.fmt(fmt_q), .swap(swap_q), .raw_a(rd_a[SAMPLE_W-1:0]), .raw_b(rd_b[SAMPLE_W-1:0]),
		.frac(phase_q[FRAC_BITS-1:0]), .raw_y(lane_l)
	);

	lir_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r (
		.fmt(fmt_q), .swap(swap_q), .raw_a(rd_a[2*SAMPLE_W-1:SAMPLE_W]),
		.raw_b(rd_b[2*SAMPLE_W-1:SAMPLE_W]),
		.frac(phase_q[FRAC_BITS-1:0]), .raw_y(lane_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			fmt_q      <= RST_SAMPLE_FORMAT;
			stereo_q   <= RST_STEREO;
			in_rate_q  <= RST_IN_RATE;
			out_rate_q <= RST_OUT_RATE;
			swap_q     <= RST_SWAP_BYTES;
			fill_q     <= '0;
			n_in_q     <= '0;
			prod_q     <= '0;
			count_q    <= '0;
			delta_q    <= '0;
			phase_q    <= '0;
			emit_cnt_q <= '0;
			emit_idx_q <= '0;
			clipped_q  <= 1'b0;
			ov_q       <= 1'b0;
			ol_q       <= '0;
			or_q       <= '0;
			olast_q    <= 1'b0;
			oclip_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_SAMPLE_FORMAT: fmt_q      <= cfg.data[1:0];
					REG_STEREO:        stereo_q   <= cfg.data[0];
					REG_IN_RATE:       in_rate_q  <= cfg.data[RATE_W-1:0];
					REG_OUT_RATE:      out_rate_q <= cfg.data[RATE_W-1:0];
					REG_SWAP_BYTES:    swap_q     <= cfg.data[0];
					default: ;
				endcase
			end
			if (results.valid && results.ready && state_q != S_LERP) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (frames.block_end) begin
							fill_q <= '0;
							n_in_q <= n_in_next;
							if (in_rate_q != '0) begin
								state_q <= S_MUL;
							end
						end else if (!store_full) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				S_MUL: begin
					prod_q  <= DIV_W'(n_in_q) * DIV_W'(out_rate_q);
					state_q <= S_CNT_GO;
				end
				S_CNT_GO: state_q <= S_CNT;
				S_CNT: begin
					if (div_done) begin
						count_q    <= div_quot;
						clipped_q  <= clip_now;
						emit_cnt_q <= clip_now ? CW'(BLOCK_FRAMES) : CW'(div_quot);
						state_q    <= (div_quot == '0) ? S_LOAD : S_STEP_GO;
					end
				end
				S_STEP_GO: state_q <= S_STEP;
				S_STEP: begin
					if (div_done) begin
						delta_q    <= div_quot;
						phase_q    <= '0;
						emit_idx_q <= '0;
						state_q    <= S_RD;
					end
				end
				S_RD: state_q <= S_LERP;
				S_LERP: begin
					if (slot_free) begin
						ov_q       <= 1'b1;
						ol_q       <= lane_l;
						or_q       <= stereo_q ? lane_r : {SAMPLE_W{1'b0}};
						olast_q    <= (emit_idx_q == emit_cnt_q - 1'b1);
						oclip_q    <= clipped_q;
						phase_q    <= phase_q + delta_q;
						emit_idx_q <= emit_idx_q + 1'b1;
						state_q    <= (emit_idx_q == emit_cnt_q - 1'b1) ? S_LOAD : S_RD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign results.valid         = ov_q;
	assign results.out_left      = ol_q;
	assign results.out_right     = or_q;
	assign results.out_last      = olast_q;
	assign results.count_clipped = oclip_q;

endmodule

`default_nettype wire

// File: hdl/lir_checker.sv
// ----------------------------------------------------------------------------
// lir_checker
// Port-level checks of the block resampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_end,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_left,
	input wire logic        out_last,
	input wire logic        cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left))
		else $error("result changed while stalled");

	a_block_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_end |=> !in_ready)
		else $error("frames taken right after block end");

	a_no_load_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("frames taken during emission");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind linear_interp_block_resampler_top lir_checker u_lir_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(frames.valid),
	.in_ready(frames.ready),
	.in_end(frames.block_end),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_left(results.out_left),
	.out_last(results.out_last),
	.cfg_ready(cfg.ready)
);

`default_nettype wire

// File: verif/tb_linear_interp_block_resampler_top.sv
// ----------------------------------------------------------------------------
// tb_linear_interp_block_resampler_top
// Self-checking bench for the block resampler. Frame blocks are loaded under
// several formats and rate ratios, every result is checked field by field
// against a built-in interpolation predictor, with random bursts and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_linear_interp_block_resampler_top;
	import lir_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int FRAC  = 12;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic                last;
	} frame_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic                last;
		logic                clipped;
	} interp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lir_in_if  frames();
	lir_out_if results();
	lir_cfg_if cfg();

	linear_interp_block_resampler_top uut (
		.clk(clk), .arst_n(arst_n), .frames(frames), .results(results), .cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	frame_t  frame_q[$];
	interp_t interp_q[$];

	// predictor state
	logic [31:0]   store_mem[DEPTH];
	int unsigned   loaded;
	logic [1:0]    fmt_m;
	logic          stereo_m;
	logic [18:0]   in_rate_m;
	logic [18:0]   out_rate_m;
	logic          swap_m;

	int errors, blocks, n_results, clip_blocks, zero_blocks;
	int hold_req, hold_done;

	function automatic logic [15:0] bswap(logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [15:0] to_offset(logic [15:0] raw);
		if (!fmt_m[1]) begin
			if (swap_m) raw = bswap(raw);
			return fmt_m[0] ? raw : (raw ^ 16'h8000);
		end
		return fmt_m[0] ? {8'h00, raw[7:0]} : {8'h00, raw[7:0] ^ 8'h80};
	endfunction

	function automatic logic [15:0] from_offset(logic [15:0] v);
		if (!fmt_m[1]) begin
			if (!fmt_m[0]) v = v ^ 16'h8000;
			return swap_m ? bswap(v) : v;
		end
		return fmt_m[0] ? {8'h00, v[7:0]} : {8'h00, v[7:0] ^ 8'h80};
	endfunction

	function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [11:0] f);
		logic [63:0] s;
		s = 64'(a) * (64'd4096 - 64'(f)) + 64'(b) * 64'(f);
		return s[FRAC+15:FRAC];
	endfunction

	task automatic resample_frame(frame_t it);
		longint unsigned cnt;
		logic [31:0] step, ph, fa, fb;
		int unsigned n_in, emit, n, n2;
		interp_t r;
		if (loaded < DEPTH) begin
			store_mem[loaded] = {stereo_m ? it.right : 16'h0000, it.left};
			loaded++;
		end
		if (!it.last) return;
		n_in = loaded;
		loaded = 0;
		blocks++;
		if (in_rate_m == 0 || n_in == 0) begin
			zero_blocks++;
			return;
		end
		cnt = (longint'(n_in) * out_rate_m) / in_rate_m;
		if (cnt == 0) begin
			zero_blocks++;
			return;
		end
		step = 32'((longint'(n_in) << FRAC) / cnt);
		emit = (cnt > DEPTH) ? DEPTH : int'(cnt);
		if (cnt > DEPTH) clip_blocks++;
		ph = 0;
		for (int i = 0; i < emit; i++) begin
			n = ph >> FRAC;
			n2 = n + 1;
			if (n > n_in - 1) n = n_in - 1;
			if (n2 > n_in - 1) n2 = n_in - 1;
			fa = store_mem[n];
			fb = store_mem[n2];
			r.left = from_offset(blend(to_offset(fa[15:0]), to_offset(fb[15:0]), ph[11:0]));
			r.right = stereo_m ?
				from_offset(blend(to_offset(fa[31:16]), to_offset(fb[31:16]), ph[11:0])) : 16'h0;
			r.last = (i + 1 == emit);
			r.clipped = (cnt > DEPTH);
			interp_q.push_back(r);
			ph += step;
		end
	endtask

	// driver
	int  gap_left, burst_left;
	logic offer;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames.valid <= 1'b0;
			frames.sample_left <= '0;
			frames.sample_right <= '0;
			frames.block_end <= 1'b0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			offer = 1'b0;
			if (frames.valid && frames.ready)
				resample_frame(frame_q.pop_front());
			else if (frames.valid)
				offer = 1'b1;
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (frame_q.size() > 0) begin
					offer = 1'b1;
					if (burst_left == 0) burst_left = $urandom_range(1, 12);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			frames.valid <= offer;
			if (offer) begin
				frames.sample_left <= frame_q[0].left;
				frames.sample_right <= frame_q[0].right;
				frames.block_end <= frame_q[0].last;
			end
		end
	end

	// monitor
	int hold_left, mode_left, stall_mode;
	logic rdy;
	interp_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			hold_left = 0;
			mode_left = 0;
			stall_mode = 0;
		end else begin
			if (results.valid && results.ready) begin
				n_results++;
				if (interp_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction left=%h right=%h", $time,
						results.out_left, results.out_right);
				end else begin
					want = interp_q.pop_front();
					if (results.out_left !== want.left) begin
						errors++;
						$display("%0t: out_left expected %h actual %h", $time,
							want.left, results.out_left);
					end
					if (results.out_right !== want.right) begin
						errors++;
						$display("%0t: out_right expected %h actual %h", $time,
							want.right, results.out_right);
					end
					if (results.out_last !== want.last) begin
						errors++;
						$display("%0t: out_last expected %b actual %b", $time,
							want.last, results.out_last);
					end
					if (results.count_clipped !== want.clipped) begin
						errors++;
						$display("%0t: count_clipped expected %b actual %b", $time,
							want.clipped, results.count_clipped);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (hold_done < hold_req) begin
				hold_done++;
				hold_left = 400;
				rdy = 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(8, 40);
				end
				mode_left--;
				case (stall_mode)
					0: rdy = 1'b1;
					1: rdy = ($urandom_range(0, 3) != 0);
					default: rdy = ($urandom_range(0, 3) == 0);
				endcase
			end
			results.ready <= rdy;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_SAMPLE_FORMAT: fmt_m = val[1:0];
			REG_STEREO:        stereo_m = val[0];
			REG_IN_RATE:       in_rate_m = val;
			REG_OUT_RATE:      out_rate_m = val;
			REG_SWAP_BYTES:    swap_m = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (frame_q.size() == 0 && !frames.valid && interp_q.size() == 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic setup(logic [1:0] f, logic st, logic [18:0] ir, logic [18:0] orr, logic sw);
		drain();
		write_reg(REG_SAMPLE_FORMAT, 19'(f));
		write_reg(REG_STEREO, 19'(st));
		write_reg(REG_IN_RATE, ir);
		write_reg(REG_OUT_RATE, orr);
		write_reg(REG_SWAP_BYTES, 19'(sw));
	endtask

	function automatic logic [15:0] pick();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return ($urandom_range(0, 1)) ? 16'h8000 : 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_block(int len);
		frame_t it;
		for (int i = 0; i < len; i++) begin
			it.left = pick();
			it.right = pick();
			it.last = (i == len - 1);
			frame_q.push_back(it);
		end
	endtask

	task automatic push_frame(logic [15:0] l, logic [15:0] r, logic e);
		frame_q.push_back('{left: l, right: r, last: e});
	endtask

	int sent;
	int len;
	logic [18:0] ir, orr;

	initial begin
		frames.valid = 1'b0;
		frames.sample_left = '0;
		frames.sample_right = '0;
		frames.block_end = 1'b0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		fmt_m = RST_SAMPLE_FORMAT;
		stereo_m = RST_STEREO;
		in_rate_m = RST_IN_RATE;
		out_rate_m = RST_OUT_RATE;
		swap_m = RST_SWAP_BYTES;
		loaded = 0;
		errors = 0; blocks = 0; n_results = 0; clip_blocks = 0; zero_blocks = 0;
		hold_req = 0; hold_done = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: one-frame block rounds to zero output, then a four-frame block
		push_frame(16'h1234, 16'h5678, 1'b1);
		push_frame(16'h0000, 16'hFFFF, 1'b0);
		push_frame(16'hFFFF, 16'h0000, 1'b0);
		push_frame(16'h8000, 16'h7FFF, 1'b0);
		push_frame(16'h7FFF, 16'h8000, 1'b1);
		// rate extremes: saturated upsampling, upsampling clamped at the last frame, equal rates, downsampling to no output
		setup(2'd1, 1'b1, 19'd1, 19'd384000, 1'b1);
		push_frame(16'h0000, 16'hFFFF, 1'b0);
		push_frame(16'hFFFF, 16'h0000, 1'b1);
		setup(2'd2, 1'b0, 19'd1000, 19'd3000, 1'b1);
		push_frame(16'hFF80, 16'hFFFF, 1'b0);
		push_frame(16'h007F, 16'h0000, 1'b0);
		push_frame(16'h0000, 16'h1111, 1'b1);
		setup(2'd3, 1'b1, 19'd384000, 19'd384000, 1'b0);
		push_frame(16'h00FF, 16'hFF00, 1'b0);
		push_frame(16'hFF00, 16'h00FF, 1'b1);
		setup(2'd0, 1'b0, 19'd384000, 19'd1, 1'b0);
		push_frame(16'hAAAA, 16'h5555, 1'b0);
		push_frame(16'h5555, 16'hAAAA, 1'b1);

		// store overflow: 70 frames, rest dropped; long receiver stall while
		// the next block keeps offering
		setup(2'd0, 1'b1, 19'd48000, 19'd24000, 1'b0);
		hold_req++;
		push_block(70);
		push_block(3);
		sent = 87;

		// random phases
		for (int p = 0; p < 4; p++) begin
			ir = 19'($urandom_range(1, 384000));
			case ($urandom_range(0, 3))
				0: orr = 19'($urandom_range(1, ir));
				1: orr = (ir > 96000) ? 19'd384000 : ir * 4;
				2: orr = ir;
				default: orr = 19'($urandom_range(1, 384000));
			endcase
			setup(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), ir, orr,
				1'($urandom_range(0, 1)));
			for (int b = 0; b < 3; b++) begin
				len = $urandom_range(1, 3);
				push_block(len);
				sent += len;
				if (p == 2 && b == 0)
					wait (frame_q.size() == 0 && interp_q.size() == 0);
			end
		end
		drain();

		$display("covered %0d blocks (%0d empty, %0d saturated), %0d results checked",
			blocks, zero_blocks, clip_blocks, n_results);
		$display("all four formats, mono and stereo, byte swap, rate extremes, store overflow");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
